### src/mmrp_pkg.sv
// Shared types and constants for the meter reply parser.
package mmrp_pkg;

  localparam int MAX_FRAME = 40;
  localparam int MIN_FRAME = 29;
  localparam int CAP_FIRST = 3;
  localparam int CAP_COUNT = 24;
  localparam int NUM_WORDS = CAP_COUNT / 4;
  localparam int IDX_W     = 6;
  localparam int CAP_IDX_W = $clog2(CAP_COUNT);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_SHIFT_MASK = 16'h7FFF;
  localparam logic [7:0]  ADDR_RESET = 8'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        address_match;
    logic        crc_match;
    logic        frame_short;
    logic        values_updated;
    logic [31:0] voltage;
    logic [31:0] current;
    logic [31:0] power;
    logic [31:0] energy;
    logic [31:0] power_factor;
    logic [31:0] co2;
  } out_t;

  typedef struct packed {
    logic address_match;
    logic crc_match;
    logic frame_short;
  } frame_check_t;

  typedef logic [CAP_COUNT-1:0][7:0] capture_t;

endpackage

### src/mmrp_crc_byte.sv
// CRC-16/Modbus update over one byte, LSB first.
module mmrp_crc_byte (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import mmrp_pkg::*;

  always_comb begin
    logic [15:0] c;
    logic        lsb;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      lsb = c[0];
      c   = (c >> 1) & CRC_SHIFT_MASK;
      if (lsb) begin
        c = c ^ CRC_POLY;
      end
    end
    crc_next = c;
  end

endmodule

### src/mmrp_frame.sv
// Per-frame tracking: byte index, CRC delay line, address and payload capture.
module mmrp_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  mmrp_pkg::in_t         data,
  input  logic [7:0]            device_address,
  output mmrp_pkg::frame_check_t check,
  output mmrp_pkg::capture_t    capture
);
  import mmrp_pkg::*;

  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]      crc_acc, crc_acc_next, crc_fed;
  logic [7:0]       delay0, delay0_next;
  logic [7:0]       delay1, delay1_next;
  logic [7:0]       frame_address, frame_address_next;
  logic             in_range;
  logic             cap_write;
  logic [CAP_IDX_W-1:0] cap_sel;

  mmrp_crc_byte u_crc (
    .crc      (crc_acc),
    .data     (delay0),
    .crc_next (crc_fed)
  );

  assign in_range  = byte_index < IDX_W'(MAX_FRAME);
  assign cap_write = accept && byte_index >= IDX_W'(CAP_FIRST)
                     && byte_index < IDX_W'(CAP_FIRST + CAP_COUNT);
  assign cap_sel   = CAP_IDX_W'(byte_index - IDX_W'(CAP_FIRST));

  always_comb begin
    byte_index_next    = byte_index;
    crc_acc_next       = crc_acc;
    delay0_next        = delay0;
    delay1_next        = delay1;
    frame_address_next = frame_address;
    if (in_range) begin
      if (byte_index >= IDX_W'(2)) begin
        crc_acc_next = crc_fed;
      end
      delay0_next = delay1;
      delay1_next = data.rx_byte;
      if (byte_index == '0) begin
        frame_address_next = data.rx_byte;
      end
      byte_index_next = byte_index + IDX_W'(1);
    end
    check.address_match = frame_address_next == device_address;
    check.crc_match     = (delay0_next == crc_acc_next[7:0])
                          && (delay1_next == crc_acc_next[15:8]);
    check.frame_short   = byte_index_next < IDX_W'(MIN_FRAME);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      crc_acc       <= CRC_INIT;
      delay0        <= '0;
      delay1        <= '0;
      frame_address <= '0;
    end else if (accept) begin
      if (data.last_byte) begin
        // frame ends: drop back to the start-of-frame state
        byte_index    <= '0;
        crc_acc       <= CRC_INIT;
        delay0        <= '0;
        delay1        <= '0;
        frame_address <= '0;
      end else begin
        byte_index    <= byte_index_next;
        crc_acc       <= crc_acc_next;
        delay0        <= delay0_next;
        delay1        <= delay1_next;
        frame_address <= frame_address_next;
      end
    end
  end

  // capture store holds no reset; only entries of the current frame are read
  always_ff @(posedge clk) begin
    if (cap_write) begin
      capture[cap_sel] <= data.rx_byte;
    end
  end

endmodule

### src/modbus_meter_response_parser.sv
// Top level of the Modbus RTU meter reply parser.
// Usage: feed the reply one byte per request on in_data, with last_byte set
// on the final byte. Requests may follow back to back. The CRC-16/Modbus
// update is done by an eight-step unrolled shift network on bytes leaving
// the delay0/delay1 line. The first byte is compared with device_address
// (reset 1, written through cfg_we/cfg_wdata; the user must write it only
// while idle, which the block does not enforce). The last two bytes of the
// frame are the CRC, low byte first. Bytes past the fortieth are ignored,
// though a final one still closes the frame. Each frame gives exactly one
// result request, registered in the cycle after its last byte is accepted.
// The six measured words (voltage, current, power, energy, power factor,
// CO2, big-endian from bytes 3 to 26) are replaced only when the address
// and CRC match and the frame has at least 29 bytes; otherwise the previous
// words are reported again. Middle bytes keep being accepted while a result
// waits; only a final byte stalls until the result register is free.
module modbus_meter_response_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  logic           in_valid,
  output logic           in_stall,
  input  mmrp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mmrp_pkg::out_t out_data
);
  import mmrp_pkg::*;

  logic                        device_address;
  logic [7:0]                  dev_addr;
  logic                        accept;
  logic                        accept_last;
  logic                        update;
  frame_check_t                check;
  capture_t                    capture;
  logic [NUM_WORDS-1:0][31:0]  measured, measured_next;

  // Hold final bytes while an untaken result sits in the output register.
  assign in_stall    = out_valid && out_stall && in_data.last_byte;
  assign accept      = in_valid && !in_stall;
  assign accept_last = accept && in_data.last_byte;
  assign update      = check.address_match && check.crc_match && !check.frame_short;
  assign device_address = dev_addr != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= ADDR_RESET;
    end else if (cfg_we) begin
      dev_addr <= cfg_wdata;
    end
  end

  mmrp_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data           (in_data),
    .device_address (dev_addr),
    .check          (check),
    .capture        (capture)
  );

  // Assemble big-endian words from the capture bytes on a good frame.
  always_comb begin
    measured_next = measured;
    if (accept_last && update) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        measured_next[k] = {capture[4*k], capture[4*k+1],
                            capture[4*k+2], capture[4*k+3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measured <= '0;
    end else begin
      measured <= measured_next;
    end
  end

  // Result register: load on an accepted final byte, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_last) begin
      out_data.address_match  <= check.address_match;
      out_data.crc_match      <= check.crc_match;
      out_data.frame_short    <= check.frame_short;
      out_data.values_updated <= update;
      out_data.voltage        <= measured_next[0];
      out_data.current        <= measured_next[1];
      out_data.power          <= measured_next[2];
      out_data.energy         <= measured_next[3];
      out_data.power_factor   <= measured_next[4];
      out_data.co2            <= measured_next[5];
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with a free result register");

  a_update_needs_checks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.values_updated) |->
      (out_data.address_match && out_data.crc_match && !out_data.frame_short))
    else $error("values updated without all checks passing");

  a_words_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept_last && update) |=> $stable(measured))
    else $error("measured words changed without a good frame");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(accept_last))
    else $error("result appeared without a final byte");

  a_addr_nonzero_tracks: assert property (@(posedge clk) disable iff (rst)
    device_address |-> (dev_addr != 8'd0))
    else $error("address flag out of step with register");

endmodule
